[hw/rtl/tczl_pkg.sv]
// ----------------------------------------------------------------------------
// tczl_pkg: shared types and constants of the three-column zone layout
// Fixed-point format, clamp limits, divider sizing and the column command
// that passes from the front part to the back part.
// ----------------------------------------------------------------------------
package tczl_pkg;

  localparam int MAX_WINDOWS = 32;
  localparam int FRAC_BITS   = 16;

  // Width of a window count (holds MAX_WINDOWS itself) and of a zone index.
  localparam int CNT_W = $clog2(MAX_WINDOWS + 1);
  localparam int IDX_W = $clog2(MAX_WINDOWS);
  // Q format coordinate: FRAC_BITS fraction bits plus one bit for 1.0.
  localparam int Q_W   = FRAC_BITS + 1;

  localparam int ONE_INT = 1 << FRAC_BITS;
  localparam logic [Q_W-1:0] ONE      = Q_W'(ONE_INT);
  localparam logic [Q_W-1:0] RATIO_LO = Q_W'((ONE_INT * 1 + 5) / 10);
  localparam logic [Q_W-1:0] RATIO_HI = Q_W'((ONE_INT * 9 + 5) / 10);

  // Configuration register indexes.
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_MASTER_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MASTER_RATIO = 1'b1;
  localparam int CFG_DATA_W = Q_W;

  // Up to three columns per layout.
  localparam int NUM_COLS = 3;
  localparam int COL_W    = 2;

  // Row height divider: one over the row count, four quotient bits a cycle.
  localparam int DIV_RADIX_BITS = 4;
  localparam int DIV_DIGITS     = (Q_W + DIV_RADIX_BITS - 1) / DIV_RADIX_BITS;
  localparam int DIV_W          = DIV_DIGITS * DIV_RADIX_BITS;
  localparam int DIV_STEP_W     = $clog2(DIV_DIGITS);
  localparam int REM_W          = CNT_W + 1;

  // Queue between front and back.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic [CNT_W-1:0] rows;
    logic [Q_W-1:0]   x;
    logic [Q_W-1:0]   w;
    logic             first;
    logic             last;
  } col_cmd_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_DIV,
    B_EMIT
  } back_state_t;

endpackage

[hw/rtl/three_column_zone_layout.sv]
// ----------------------------------------------------------------------------
// three_column_zone_layout: three-column tiling layout engine
// Turns a window count into one normalized Q16 rectangle per window.
// ----------------------------------------------------------------------------
// Each accepted window count, clamped to MAX_WINDOWS, yields one rectangle
// per window (none for a count of zero), delivered in zone order with last
// set on the final one. The layout is built column by column: the front
// stage classifies the count and queues up to three column commands, and
// the back stage fetches a command, runs the radix-16 row height divider
// and then emits one rectangle per row whenever the output register is
// free. The front takes the next count as soon as the previous one has
// been queued.
// Configuration writes take effect on the next accepted count.
module three_column_zone_layout
  import tczl_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  push,
  output logic                  full,
  input  logic [CNT_W-1:0]      window_count,
  output logic                  empty,
  input  logic                  pop,
  output logic [IDX_W-1:0]      zone_index,
  output logic [Q_W-1:0]        pos_x,
  output logic [Q_W-1:0]        pos_y,
  output logic [Q_W-1:0]        width,
  output logic [Q_W-1:0]        height,
  output logic                  last
);

  logic     q_push;
  col_cmd_t q_wdata;
  logic     q_full;
  logic     q_pop;
  col_cmd_t q_rdata;
  logic     q_empty;

  tczl_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .push         (push),
    .full         (full),
    .window_count (window_count),
    .q_push       (q_push),
    .q_data       (q_wdata),
    .q_full       (q_full)
  );

  tczl_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .q_push  (q_push),
    .q_wdata (q_wdata),
    .q_full  (q_full),
    .q_pop   (q_pop),
    .q_rdata (q_rdata),
    .q_empty (q_empty)
  );

  tczl_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_rdata    (q_rdata),
    .q_empty    (q_empty),
    .q_pop      (q_pop),
    .empty      (empty),
    .pop        (pop),
    .zone_index (zone_index),
    .pos_x      (pos_x),
    .pos_y      (pos_y),
    .width      (width),
    .height     (height),
    .last       (last)
  );

endmodule

[hw/rtl/tczl_front.sv]
// ----------------------------------------------------------------------------
// tczl_front: configuration registers and layout classification
// Takes a window count, decides the column split and hands one command per
// column to the queue.
// ----------------------------------------------------------------------------
module tczl_front
  import tczl_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  push,
  output logic                  full,
  input  logic [CNT_W-1:0]      window_count,
  output logic                  q_push,
  output col_cmd_t              q_data,
  input  logic                  q_full
);

  logic [CNT_W-1:0] master_count;
  logic [Q_W-1:0]   master_ratio;

  col_cmd_t         cols [NUM_COLS];
  logic [COL_W-1:0] ncol;
  logic [COL_W-1:0] ptr;

  logic [CNT_W-1:0] n_c, m_c, stack_c, right_c, left_c;
  logic [Q_W-1:0]   centre_c, side_c, cx_c, rx_c;
  logic [COL_W-1:0] ncol_c;
  col_cmd_t         cols_next [NUM_COLS];
  logic             busy;
  logic             accept;

  assign busy   = (ptr != ncol);
  assign full   = busy;
  assign accept = push && !full;
  assign q_push = busy && !q_full;
  assign q_data = cols[ptr];

  always_comb begin
    n_c = (window_count > CNT_W'(MAX_WINDOWS)) ? CNT_W'(MAX_WINDOWS) : window_count;
    m_c = (master_count > n_c) ? n_c : master_count;
    if (m_c == '0) begin
      m_c = CNT_W'(1);
    end
    stack_c = n_c - m_c;
    right_c = CNT_W'(stack_c[CNT_W-1:1]) + CNT_W'(stack_c[0]);
    left_c  = CNT_W'(stack_c[CNT_W-1:1]);

    centre_c = master_ratio;
    if (centre_c < RATIO_LO) begin
      centre_c = RATIO_LO;
    end
    if (centre_c > RATIO_HI) begin
      centre_c = RATIO_HI;
    end

    if (left_c != '0) begin
      side_c = (ONE - centre_c) >> 1;
      cx_c   = side_c;
      rx_c   = side_c + centre_c;
    end else begin
      side_c = ONE - centre_c;
      cx_c   = '0;
      rx_c   = centre_c;
    end

    // With no stack windows the masters take the whole width.
    if (n_c == '0) begin
      ncol_c = '0;
    end else if (stack_c == '0) begin
      ncol_c = COL_W'(1);
    end else if (left_c == '0) begin
      ncol_c = COL_W'(2);
    end else begin
      ncol_c = COL_W'(3);
    end

    cols_next[0].rows = m_c;
    cols_next[0].x    = (stack_c == '0) ? '0 : cx_c;
    cols_next[0].w    = (stack_c == '0) ? ONE : centre_c;
    cols_next[1].rows = right_c;
    cols_next[1].x    = rx_c;
    cols_next[1].w    = side_c;
    cols_next[2].rows = left_c;
    cols_next[2].x    = '0;
    cols_next[2].w    = side_c;
    for (int i = 0; i < NUM_COLS; i++) begin
      cols_next[i].first = (i == 0);
      cols_next[i].last  = (COL_W'(i) == ncol_c - COL_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      master_count <= CNT_W'(1);
      master_ratio <= Q_W'(ONE_INT / 2);
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_MASTER_COUNT: master_count <= cfg_data[CNT_W-1:0];
        REG_MASTER_RATIO: master_ratio <= cfg_data[Q_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ncol <= '0;
      ptr  <= '0;
    end else if (accept) begin
      ncol <= ncol_c;
      ptr  <= '0;
    end else if (q_push) begin
      ptr <= ptr + COL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < NUM_COLS; i++) begin
        cols[i] <= cols_next[i];
      end
    end
  end

endmodule

[hw/rtl/tczl_queue.sv]
// ----------------------------------------------------------------------------
// tczl_queue: column command queue
// A short first-in first-out buffer that decouples classification from
// rectangle generation.
// ----------------------------------------------------------------------------
module tczl_queue
  import tczl_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     q_push,
  input  col_cmd_t q_wdata,
  output logic     q_full,
  input  logic     q_pop,
  output col_cmd_t q_rdata,
  output logic     q_empty
);

  col_cmd_t            entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QPTR_W:0]     count;
  logic                do_push;
  logic                do_pop;

  assign q_full  = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign q_empty = (count == '0);
  assign do_push = q_push && !q_full;
  assign do_pop  = q_pop && !q_empty;
  assign q_rdata = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + (QPTR_W+1)'(1);
      end else if (do_pop && !do_push) begin
        count <= count - (QPTR_W+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= q_wdata;
    end
  end

endmodule

[hw/rtl/tczl_back.sv]
// ----------------------------------------------------------------------------
// tczl_back: row generator
// Takes one column command, divides 1.0 by the row count, then emits one
// rectangle per row into the output register.
// ----------------------------------------------------------------------------
module tczl_back
  import tczl_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  col_cmd_t          q_rdata,
  input  logic              q_empty,
  output logic              q_pop,
  output logic              empty,
  input  logic              pop,
  output logic [IDX_W-1:0]  zone_index,
  output logic [Q_W-1:0]    pos_x,
  output logic [Q_W-1:0]    pos_y,
  output logic [Q_W-1:0]    width,
  output logic [Q_W-1:0]    height,
  output logic              last
);

  back_state_t state, state_next;

  col_cmd_t              cmd;
  logic [IDX_W-1:0]      k;
  logic [CNT_W-1:0]      i;
  logic [Q_W-1:0]        y;
  logic [Q_W-1:0]        row;
  logic [REM_W-1:0]      rem;
  logic [DIV_W-1:0]      num;
  logic [DIV_W-1:0]      quo;
  logic [DIV_STEP_W-1:0] step;
  logic                  out_valid;

  logic [REM_W-1:0]      rem_next;
  logic [DIV_W-1:0]      num_next;
  logic [DIV_W-1:0]      quo_next;
  logic                  can_emit;
  logic                  emit;
  logic                  last_row;

  assign empty    = !out_valid;
  assign can_emit = !out_valid || pop;
  assign last_row = (i == cmd.rows - CNT_W'(1));
  assign emit     = (state == B_EMIT) && can_emit;
  assign q_pop    = (state == B_IDLE) && !q_empty;

  // Restoring division, several quotient bits per cycle.
  always_comb begin
    rem_next = rem;
    num_next = num;
    quo_next = quo;
    for (int j = 0; j < DIV_RADIX_BITS; j++) begin
      rem_next = {rem_next[REM_W-2:0], num_next[DIV_W-1]};
      num_next = num_next << 1;
      quo_next = quo_next << 1;
      if (rem_next >= {1'b0, cmd.rows}) begin
        rem_next    = rem_next - {1'b0, cmd.rows};
        quo_next[0] = 1'b1;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE: begin
        if (!q_empty) begin
          state_next = B_DIV;
        end
      end
      B_DIV: begin
        if (step == DIV_STEP_W'(DIV_DIGITS - 1)) begin
          state_next = B_EMIT;
        end
      end
      B_EMIT: begin
        if (can_emit && last_row) begin
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      k         <= '0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
        k         <= k + IDX_W'(1);
      end else if (pop) begin
        out_valid <= 1'b0;
      end
      if (q_pop && q_rdata.first) begin
        k <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      B_IDLE: begin
        if (!q_empty) begin
          cmd  <= q_rdata;
          rem  <= '0;
          num  <= DIV_W'(ONE);
          quo  <= '0;
          step <= '0;
        end
      end
      B_DIV: begin
        rem  <= rem_next;
        num  <= num_next;
        quo  <= quo_next;
        step <= step + DIV_STEP_W'(1);
        y    <= '0;
        i    <= '0;
        row  <= quo_next[Q_W-1:0];
      end
      B_EMIT: begin
        if (can_emit) begin
          zone_index <= k;
          pos_x      <= cmd.x;
          pos_y      <= y;
          width      <= cmd.w;
          // The bottom row takes up the rounding remainder.
          height     <= last_row ? (ONE - y) : row;
          last       <= last_row && cmd.last;
          y          <= y + row;
          i          <= i + CNT_W'(1);
        end
      end
      default: ;
    endcase
  end

endmodule

[hw/rtl/tczl_checker.sv]
// ----------------------------------------------------------------------------
// tczl_checker: port-level assertions for the zone layout
// Watches the result queue interface and checks rectangle geometry.
// ----------------------------------------------------------------------------
module tczl_checker
  import tczl_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             empty,
  input logic             pop,
  input logic [IDX_W-1:0] zone_index,
  input logic [Q_W-1:0]   pos_x,
  input logic [Q_W-1:0]   pos_y,
  input logic [Q_W-1:0]   width,
  input logic [Q_W-1:0]   height,
  input logic             last
);

  // No result is offered right after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result offered after reset");

  // A waiting result holds its zone index, y position, height and last flag until it is popped.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(zone_index) && $stable(pos_y)
                          && $stable(height) && $stable(last)))
    else $error("waiting result changed");

  // A single-zone layout covers the whole screen.
  a_single_full: assert property (@(posedge clk) disable iff (rst)
    (!empty && last && zone_index == '0) |->
      (pos_x == '0 && pos_y == '0 && width == ONE && height == ONE))
    else $error("single zone is not full screen");

  // The final zone sits in the bottom row of its column.
  a_last_bottom: assert property (@(posedge clk) disable iff (rst)
    (!empty && last) |-> ({1'b0, pos_y} + {1'b0, height} == {1'b0, ONE}))
    else $error("final zone does not reach the bottom edge");

endmodule

bind three_column_zone_layout tczl_checker u_tczl_checker (
  .clk        (clk),
  .rst        (rst),
  .empty      (empty),
  .pop        (pop),
  .zone_index (zone_index),
  .pos_x      (pos_x),
  .pos_y      (pos_y),
  .width      (width),
  .height     (height),
  .last       (last)
);
